// File: rtl/core/itrf_pkg.sv
// Shared types and constants for the I2C target register file.
package itrf_pkg;

    // Number of registers in the map and the index width it needs.
    localparam int REG_COUNT = 64;
    localparam int IDX_W     = $clog2(REG_COUNT);
    localparam logic [7:0] REG_COUNT_B = 8'(REG_COUNT);

    localparam logic [7:0] OUT_OF_RANGE_BYTE = 8'hFF;

    // Item commands; the eighth code is unused and leaves the state and the map unchanged.
    typedef enum logic [2:0] {
        CMD_ADDR_WR  = 3'd0,
        CMD_RX_BYTE  = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_TX_REQ   = 3'd3,
        CMD_LOCAL_WR = 3'd4,
        CMD_CLR_FLAG = 3'd5,
        CMD_LOCAL_RD = 3'd6
    } t_cmd;

    // Configuration register indexes.
    localparam logic [7:0] CFG_STREAM_ADDR = 8'd0;
    localparam logic [7:0] CFG_CALIB_ADDR  = 8'd1;
    localparam logic [7:0] CFG_DONE_CODE   = 8'd2;
    localparam logic [7:0] CFG_IDLE_CODE   = 8'd3;

    // Configuration reset values.
    localparam logic [7:0] RST_DONE_CODE = 8'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the item and read the register map
        logic execute;   // update state, write the map, load the result
    } t_ctrl_cmd;

endpackage

// File: rtl/core/i2c_target_register_file.sv
// Top level of the I2C target register file: controller plus datapath.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_cmd, i_rx_byte, i_stream_valid,
//                                                  i_stream_byte, i_local_addr, i_local_data
//  result    out        o_out_valid / i_out_stall  o_tx_byte, o_stream_take, o_update_flag,
//                                                  o_write_count, o_first_reg, o_local_rd_data
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each item has two steps: capture latches it and reads the register map (the
// map's single registered read port), then execute updates state and writes the map.
// The execute step waits while the previous result is still stalled.
// Reset is synchronous, active low; it clears pointer, flags, counts and the
// per-entry valid bits of the map at once, so no clearing pass is needed.
// The config port is always ready.
module i2c_target_register_file
    import itrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input items
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_rx_byte,
    input  logic       i_stream_valid,
    input  logic [7:0] i_stream_byte,
    input  logic [7:0] i_local_addr,
    input  logic [7:0] i_local_data,
    // Result items
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_stream_take,
    output logic       o_update_flag,
    output logic [7:0] o_write_count,
    output logic [7:0] o_first_reg,
    output logic [7:0] o_local_rd_data,
    // Configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_ctrl_cmd cmd;

    // Config writes are registered and never back-pressure
    assign o_cfg_ready = 1'b1;

    // Sequence capture and execute, own the result valid
    itrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Hold the map, the pointer state and the result fields
    itrf_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cmd_code      (i_cmd),
        .i_rx_byte       (i_rx_byte),
        .i_stream_valid  (i_stream_valid),
        .i_stream_byte   (i_stream_byte),
        .i_local_addr    (i_local_addr),
        .i_local_data    (i_local_data),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_tx_byte       (o_tx_byte),
        .o_stream_take   (o_stream_take),
        .o_update_flag   (o_update_flag),
        .o_write_count   (o_write_count),
        .o_first_reg     (o_first_reg),
        .o_local_rd_data (o_local_rd_data)
    );

endmodule

// File: rtl/core/itrf_ctrl.sv
// Controller state machine for the I2C target register file.
module itrf_ctrl
    import itrf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_stall,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_vld;

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.execute = (r_state == S_EXEC) && (!r_out_vld || !i_out_stall);
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (o_cmd.execute) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_cmd.execute) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    a_capture_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC))
        else $error("capture not followed by execute state");

    a_exec_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> (r_out_vld && r_state == S_IDLE))
        else $error("execute did not present a result");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.execute))
        else $error("capture and execute in the same cycle");

endmodule

// File: rtl/core/itrf_dpath.sv
// Datapath: register map, pointer, write tracking and result registers.
module itrf_dpath
    import itrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    input  logic [2:0] i_cmd_code,
    input  logic [7:0] i_rx_byte,
    input  logic       i_stream_valid,
    input  logic [7:0] i_stream_byte,
    input  logic [7:0] i_local_addr,
    input  logic [7:0] i_local_data,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic [7:0] o_tx_byte,
    output logic       o_stream_take,
    output logic       o_update_flag,
    output logic [7:0] o_write_count,
    output logic [7:0] o_first_reg,
    output logic [7:0] o_local_rd_data
);

    // Configuration
    logic [7:0] r_stream_addr, r_calib_addr, r_done_code, r_idle_code;

    // Protocol state
    logic [7:0] r_ptr, n_ptr;
    logic       r_expect, n_expect;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_begin, n_begin;
    logic       r_updated, n_updated;

    // Latched item
    logic [2:0] r_cmd;
    logic [7:0] r_rx, r_sbyte, r_laddr, r_ldata;
    logic       r_svalid;

    // Register map with per-entry valid bits; invalid entries read as zero
    logic [7:0]     mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [7:0]     r_rd_data;
    logic           r_rd_vld;
    logic [7:0]     rd_val;
    logic [7:0]     rd_addr;
    logic           rd_in_range;

    // Write port
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_data;

    // Result
    logic [7:0] r_tx, n_tx, r_lrd, n_lrd;
    logic       r_take, n_take;

    assign rd_addr     = (i_cmd_code == CMD_LOCAL_RD) ? i_local_addr : r_ptr;
    assign rd_in_range = (rd_addr < REG_COUNT_B);
    assign rd_val      = r_rd_vld ? r_rd_data : 8'd0;

    always_comb begin
        n_ptr     = r_ptr;
        n_expect  = r_expect;
        n_cnt     = r_cnt;
        n_begin   = r_begin;
        n_updated = r_updated;
        n_tx      = 8'd0;
        n_take    = 1'b0;
        n_lrd     = 8'd0;
        wr_en     = 1'b0;
        wr_idx    = r_ptr[IDX_W-1:0];
        wr_data   = r_rx;
        case (r_cmd)
            CMD_ADDR_WR: begin
                n_cnt    = 8'd0;
                n_begin  = 8'd0;
                n_expect = 1'b1;
            end
            CMD_RX_BYTE: begin
                if (r_expect) begin
                    n_expect = 1'b0;
                    n_ptr    = r_rx;
                    n_begin  = r_rx;
                end else if (r_ptr < REG_COUNT_B) begin
                    wr_en = 1'b1;
                    n_ptr = r_ptr + 8'd1;
                    n_cnt = r_cnt + 8'd1;
                end
            end
            CMD_STOP: begin
                if (r_cnt != 8'd0) n_updated = 1'b1;
            end
            CMD_TX_REQ: begin
                if (r_ptr == r_stream_addr && r_svalid) begin
                    n_tx   = r_sbyte;
                    n_take = 1'b1;
                end else if (r_ptr < REG_COUNT_B) begin
                    n_tx = rd_val;
                    // Clear a completed calibration status once it is read
                    if (r_ptr == r_calib_addr && rd_val == r_done_code) begin
                        wr_en   = 1'b1;
                        wr_data = r_idle_code;
                    end
                    n_ptr = r_ptr + 8'd1;
                end else begin
                    n_tx = OUT_OF_RANGE_BYTE;
                end
            end
            CMD_LOCAL_WR: begin
                if (r_laddr < REG_COUNT_B) begin
                    wr_en   = 1'b1;
                    wr_idx  = r_laddr[IDX_W-1:0];
                    wr_data = r_ldata;
                end
            end
            CMD_CLR_FLAG: n_updated = 1'b0;
            CMD_LOCAL_RD: n_lrd = (r_laddr < REG_COUNT_B) ? rd_val : OUT_OF_RANGE_BYTE;
            default: ;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_addr <= 8'd0;
            r_calib_addr  <= 8'd0;
            r_done_code   <= RST_DONE_CODE;
            r_idle_code   <= 8'd0;
            r_ptr         <= 8'd0;
            r_expect      <= 1'b0;
            r_cnt         <= 8'd0;
            r_begin       <= 8'd0;
            r_updated     <= 1'b0;
            r_vld         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STREAM_ADDR: r_stream_addr <= i_cfg_data;
                    CFG_CALIB_ADDR:  r_calib_addr  <= i_cfg_data;
                    CFG_DONE_CODE:   r_done_code   <= i_cfg_data;
                    CFG_IDLE_CODE:   r_idle_code   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.execute) begin
                r_ptr     <= n_ptr;
                r_expect  <= n_expect;
                r_cnt     <= n_cnt;
                r_begin   <= n_begin;
                r_updated <= n_updated;
                if (wr_en) r_vld[wr_idx] <= 1'b1;
            end
        end
    end

    // Item capture, map read, map write, result load
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd     <= i_cmd_code;
            r_rx      <= i_rx_byte;
            r_svalid  <= i_stream_valid;
            r_sbyte   <= i_stream_byte;
            r_laddr   <= i_local_addr;
            r_ldata   <= i_local_data;
            r_rd_data <= mem[rd_addr[IDX_W-1:0]];
            r_rd_vld  <= rd_in_range && r_vld[rd_addr[IDX_W-1:0]];
        end
        if (i_cmd.execute) begin
            r_tx   <= n_tx;
            r_take <= n_take;
            r_lrd  <= n_lrd;
            if (wr_en) mem[wr_idx] <= wr_data;
        end
    end

    assign o_tx_byte       = r_tx;
    assign o_stream_take   = r_take;
    assign o_local_rd_data = r_lrd;
    assign o_update_flag   = r_updated;
    assign o_write_count   = r_cnt;
    assign o_first_reg     = r_begin;

endmodule
